// ===== hw/rtl/c3e_pkg.sv =====
// Package for the 3x3 convolution engine: sizes, mode codes, register indexes.
// Used by the top level of the engine; depends on nothing.
`default_nettype none
package c3e_pkg;
    localparam int MaxSide      = 32;
    localparam int MinSide      = 4;
    localparam int MaxChannels  = 16;
    localparam int ChannelGroup = 8;
    localparam int DataWidth    = 16;
    localparam int AccWidth     = 40;
    localparam int Taps         = 9;

    localparam logic [1:0] ModeWeight  = 2'd0;
    localparam logic [1:0] ModePixel   = 2'd1;
    localparam logic [1:0] ModeCompute = 2'd2;

    localparam logic [1:0] RegSide     = 2'd0;
    localparam logic [1:0] RegChannels = 2'd1;
    localparam logic [1:0] RegPad      = 2'd2;
endpackage
`default_nettype wire

// ===== hw/rtl/c3e_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module c3e_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/c3e_mac.sv =====
// One channel lane: registered product and accumulator.
// Does not use c3e_pkg; instanced once per channel by the top level.
`default_nettype none
module c3e_mac #(
    parameter int DATA_W = 16,
    parameter int ACC_W  = 40
) (
    input  wire logic                     clk,
    input  wire logic                     clear,
    input  wire logic                     mul_en,
    input  wire logic                     acc_en,
    input  wire logic signed [DATA_W-1:0] pix,
    input  wire logic signed [DATA_W-1:0] wgt,
    output logic signed [ACC_W-1:0]       acc
);
    logic signed [2*DATA_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= pix * wgt;
        end
        if (clear)
        begin
            acc <= '0;
        end
        else if (acc_en)
        begin
            acc <= acc + ACC_W'(prod_reg);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/conv3x3_multi_channel_engine.sv =====
// Top level of the 3x3 convolution engine: control sequencer, stores and MAC lanes.
// Depends on c3e_pkg, c3e_ram and c3e_mac.
// Load items are written only while idle. A compute item splits its index into output
// row and column by repeated subtraction, steps through the 3x3 taps of each group of
// eight channels, drains, then gives one result per cycle per channel. Busy stays high
// until the last result; an index outside the output area is ignored. An invalid setting
// gives one flagged result the cycle after acceptance. Reset restores side 32, eight
// channels and no padding; the stores are not cleared. The receiver cannot stall results.
`default_nettype none
module conv3x3_multi_channel_engine #(
    parameter int MAX_SIDE      = c3e_pkg::MaxSide,
    parameter int MIN_SIDE      = c3e_pkg::MinSide,
    parameter int MAX_CHANNELS  = c3e_pkg::MaxChannels,
    parameter int CHANNEL_GROUP = c3e_pkg::ChannelGroup,
    parameter int DATA_WIDTH    = c3e_pkg::DataWidth,
    parameter int ACC_WIDTH     = c3e_pkg::AccWidth
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   mode,
    input  wire logic [9:0]                   item_index,
    input  wire logic signed [DATA_WIDTH-1:0] item_value,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [5:0]                   cfg_data,
    output logic                              result_valid,
    output logic signed [ACC_WIDTH-1:0]       conv_sum,
    output logic [3:0]                        out_channel,
    output logic [9:0]                        out_position,
    output logic                              status,
    output logic                              last_of_run
);
    localparam int PixDepth = MAX_SIDE * MAX_SIDE;
    localparam int WgtRows  = MAX_CHANNELS / CHANNEL_GROUP;
    localparam int Groups   = WgtRows;
    localparam int PixAw    = $clog2(PixDepth);
    localparam int RowAw    = (WgtRows > 1) ? $clog2(WgtRows * c3e_pkg::Taps)
                                            : $clog2(c3e_pkg::Taps);
    localparam int RowDepth = WgtRows * c3e_pkg::Taps;
    localparam int SideW    = $clog2(MAX_SIDE + 3);
    localparam int ChW      = $clog2(MAX_CHANNELS + 1);
    localparam int GrpW     = (Groups > 1) ? $clog2(Groups) : 1;

    typedef enum logic [2:0] {IDLE, DIVIDE, TAPS, DRAIN, EMIT} state_t;

    state_t state_reg;
    logic [5:0] side_reg;
    logic [4:0] chans_reg;
    logic       pad_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= 6'd32;
            chans_reg <= 5'd8;
            pad_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                c3e_pkg::RegSide:     side_reg  <= cfg_data;
                c3e_pkg::RegChannels: chans_reg <= cfg_data[4:0];
                c3e_pkg::RegPad:      pad_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Configuration check and output side, computed from the registers.
    logic [SideW-1:0] os_full;
    logic [SideW-1:0] out_side;
    logic             cfg_ok;
    logic [19:0]      os_sq;
    assign os_full  = SideW'(side_reg) + SideW'({pad_reg, 1'b0});
    assign out_side = os_full - SideW'(2);
    assign os_sq    = 20'(out_side) * 20'(out_side);
    always_comb
    begin
        cfg_ok = (side_reg >= 6'(MIN_SIDE)) && (32'(side_reg) <= MAX_SIDE)
               && (side_reg != 6'd0) && ((side_reg & (side_reg - 6'd1)) == 6'd0)
               && (chans_reg != 5'd0) && (32'(chans_reg) <= MAX_CHANNELS)
               && ((32'(chans_reg) % CHANNEL_GROUP) == 0) && (os_full >= SideW'(3));
    end

    // ---------------- stores ----------------
    // The weight store holds one row per (group, tap) with CHANNEL_GROUP lanes,
    // written one lane at a time through a separate memory and write enable per lane.
    logic [9:0]              idx_reg;
    logic [9:0]              oy_reg;
    logic [9:0]              ox_reg;
    logic [3:0]              tap_reg;
    logic [GrpW-1:0]         grp_reg;
    logic [ChW-1:0]          emit_reg;
    logic [PixAw-1:0]        pix_rd_addr;
    logic signed [DATA_WIDTH-1:0] pix_rd;
    logic                    pix_zero_reg;
    logic [RowAw-1:0]        wgt_rd_addr;

    logic pix_we;
    assign pix_we = start && !busy && (mode == c3e_pkg::ModePixel)
                  && (32'(item_index) < PixDepth);

    c3e_ram #(.WIDTH(DATA_WIDTH), .DEPTH(PixDepth)) u_pix (
        .clk(clk), .wr_en(pix_we), .wr_addr(item_index[PixAw-1:0]),
        .wr_data(item_value), .rd_addr(pix_rd_addr), .rd_data(pix_rd)
    );

    // Weight address channel*9+tap split into lane, group and tap.
    logic [9:0] w_ch;
    logic [3:0] w_tap;
    always_comb
    begin
        w_ch  = 10'((32'(item_index) * 7282) >> 16);
        w_tap = 4'(item_index - 10'(w_ch * 10'd9));
        if (w_tap >= 4'd9)
        begin
            w_ch  = w_ch + 10'd1;
            w_tap = w_tap - 4'd9;
        end
    end

    logic signed [DATA_WIDTH-1:0] wgt_rd [CHANNEL_GROUP];
    genvar g;
    generate
        for (g = 0; g < CHANNEL_GROUP; g++)
        begin : g_wlane
            logic we;
            logic [RowAw-1:0] wa;
            assign we = start && !busy && (mode == c3e_pkg::ModeWeight)
                      && (32'(item_index) < MAX_CHANNELS * c3e_pkg::Taps)
                      && (32'(w_ch) % CHANNEL_GROUP == g);
            assign wa = RowAw'(32'(w_ch) / CHANNEL_GROUP * c3e_pkg::Taps + 32'(w_tap));
            c3e_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RowDepth)) u_w (
                .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(item_value),
                .rd_addr(wgt_rd_addr), .rd_data(wgt_rd[g])
            );
        end
    endgenerate

    // ---------------- tap address generation ----------------
    logic [1:0]  ky, kx;
    logic [10:0] py, px;
    logic        tap_oob;
    always_comb
    begin
        ky = (tap_reg >= 4'd6) ? 2'd2 : ((tap_reg >= 4'd3) ? 2'd1 : 2'd0);
        kx = 2'(tap_reg - 4'(ky) * 4'd3);
        py = 11'(oy_reg) + 11'(ky) - 11'(pad_reg);
        px = 11'(ox_reg) + 11'(kx) - 11'(pad_reg);
        tap_oob = py[10] || px[10] || (py >= 11'(side_reg)) || (px >= 11'(side_reg));
        pix_rd_addr = PixAw'(py[9:0] * 10'(side_reg) + px[9:0]);
        wgt_rd_addr = RowAw'(32'(grp_reg) * c3e_pkg::Taps + 32'(tap_reg));
    end

    // ---------------- sequencer ----------------
    logic [9:0] div_rem_reg;
    logic [9:0] div_q_reg;
    logic       mul_en_reg, clear_reg;
    logic signed [ACC_WIDTH-1:0] acc [MAX_CHANNELS];
    logic       bad_reg;
    logic       pipe_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            busy         <= 1'b0;
            result_valid <= 1'b0;
            mul_en_reg   <= 1'b0;
            clear_reg    <= 1'b0;
            pipe_v_reg   <= 1'b0;
            tap_reg      <= '0;
            grp_reg      <= '0;
            emit_reg     <= '0;
            idx_reg      <= '0;
            oy_reg       <= '0;
            ox_reg       <= '0;
            div_rem_reg  <= '0;
            div_q_reg    <= '0;
            bad_reg      <= 1'b0;
            pix_zero_reg <= 1'b0;
            conv_sum     <= '0;
            out_channel  <= '0;
            out_position <= '0;
            status       <= 1'b0;
            last_of_run  <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            clear_reg    <= 1'b0;
            // Read data arrives the cycle after the address, and the product is registered from it.
            pipe_v_reg   <= 1'b0;
            mul_en_reg   <= pipe_v_reg;
            unique case (state_reg)
                IDLE:
                begin
                    if (start && mode == c3e_pkg::ModeCompute)
                    begin
                        idx_reg <= item_index;
                        if (!cfg_ok)
                        begin
                            result_valid <= 1'b1;
                            conv_sum     <= '0;
                            out_channel  <= '0;
                            out_position <= item_index;
                            status       <= 1'b1;
                            last_of_run  <= 1'b1;
                            busy         <= 1'b1;
                            state_reg    <= DRAIN;
                            bad_reg      <= 1'b1;
                        end
                        else if (20'(item_index) < os_sq)
                        begin
                            busy        <= 1'b1;
                            div_rem_reg <= item_index;
                            div_q_reg   <= '0;
                            clear_reg   <= 1'b1;
                            grp_reg     <= '0;
                            state_reg   <= DIVIDE;
                        end
                    end
                end
                DIVIDE:
                begin
                    // Repeated subtraction splits the index into row and column.
                    if (div_rem_reg >= 10'(out_side))
                    begin
                        div_rem_reg <= div_rem_reg - 10'(out_side);
                        div_q_reg   <= div_q_reg + 10'd1;
                    end
                    else
                    begin
                        oy_reg    <= div_q_reg;
                        ox_reg    <= div_rem_reg;
                        tap_reg   <= '0;
                        state_reg <= TAPS;
                    end
                end
                TAPS:
                begin
                    pipe_v_reg   <= 1'b1;
                    pix_zero_reg <= tap_oob;
                    if (tap_reg == 4'd8)
                    begin
                        tap_reg <= '0;
                        if (32'(grp_reg) + 1 < 32'(chans_reg) / CHANNEL_GROUP)
                        begin
                            grp_reg <= grp_reg + GrpW'(1);
                        end
                        else
                        begin
                            state_reg <= DRAIN;
                        end
                    end
                    else
                    begin
                        tap_reg <= tap_reg + 4'd1;
                    end
                end
                DRAIN:
                begin
                    bad_reg <= 1'b0;
                    if (bad_reg)
                    begin
                        busy      <= 1'b0;
                        state_reg <= IDLE;
                    end
                    else if (!pipe_v_reg && !mul_en_reg)
                    begin
                        emit_reg  <= '0;
                        state_reg <= EMIT;
                    end
                end
                EMIT:
                begin
                    result_valid <= 1'b1;
                    conv_sum     <= acc[emit_reg[$clog2(MAX_CHANNELS)-1:0]];
                    out_channel  <= 4'(emit_reg);
                    out_position <= idx_reg;
                    status       <= 1'b0;
                    last_of_run  <= (5'(emit_reg) + 5'd1 == chans_reg);
                    emit_reg     <= emit_reg + ChW'(1);
                    if (5'(emit_reg) + 5'd1 == chans_reg)
                    begin
                        busy      <= 1'b0;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    // Group index travels with the pipeline so each lane feeds the right accumulator.
    logic [GrpW-1:0] grp_d1, grp_d2;
    always_ff @(posedge clk)
    begin
        grp_d1 <= grp_reg;
        grp_d2 <= grp_d1;
    end

    logic signed [DATA_WIDTH-1:0] pix_eff;
    assign pix_eff = pix_zero_reg ? '0 : pix_rd;

    genvar c;
    generate
        for (c = 0; c < MAX_CHANNELS; c++)
        begin : g_mac
            localparam int Lane = c % CHANNEL_GROUP;
            localparam int Grp  = c / CHANNEL_GROUP;
            c3e_mac #(.DATA_W(DATA_WIDTH), .ACC_W(ACC_WIDTH)) u_mac (
                .clk(clk), .clear(clear_reg),
                .mul_en(pipe_v_reg && 32'(grp_d1) == Grp),
                .acc_en(mul_en_reg && 32'(grp_d2) == Grp),
                .pix(pix_eff), .wgt(wgt_rd[Lane]), .acc(acc[c])
            );
        end
    endgenerate
endmodule
`default_nettype wire
